// File: rtl/htg_pkg.sv
// ----------------------------------------------------------------------------
// htg_pkg: shared types and constants of the head-turn gesture detector
// register map, reset values, controller states and the command/status bundles
// ----------------------------------------------------------------------------
package htg_pkg;

	localparam int unsigned MAX_WINDOW_DEF = 64;

	// field widths
	localparam int unsigned YAW_W      = 9;
	localparam int unsigned NOW_W      = 32;
	localparam int unsigned WIN_W      = 7;
	localparam int unsigned ANGLE_W    = 8;
	localparam int unsigned TIMEOUT_W  = 16;
	localparam int unsigned HOLD_W     = 8;
	localparam int unsigned TURN_W     = 4;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// register reset values
	localparam logic [WIN_W-1:0]     SHORT_WINDOW_RST = 7'd5;
	localparam logic [WIN_W-1:0]     LONG_WINDOW_RST  = 7'd10;
	localparam logic [ANGLE_W-1:0]   TRIGGER_RST      = 8'd30;
	localparam logic [ANGLE_W-1:0]   RELEASE_RST      = 8'd15;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST      = 16'd120;
	localparam logic [HOLD_W-1:0]    HOLD_RST         = 8'd20;
	localparam logic [TURN_W-1:0]    TURNS_RST        = 4'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHORT_WINDOW    = 3'd0,
		REG_LONG_WINDOW     = 3'd1,
		REG_TRIGGER_ANGLE   = 3'd2,
		REG_RELEASE_ANGLE   = 3'd3,
		REG_TIMEOUT_SECONDS = 3'd4,
		REG_HOLD_FRAMES     = 3'd5,
		REG_TURNS_NEEDED    = 3'd6
	} htg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_SUM,
		ST_DRAIN,
		ST_DECIDE,
		ST_SETTLE,
		ST_EMIT
	} htg_state_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic issue;
		logic decide;
		logic settle;
		logic emit;
	} htg_cmd_t;

	typedef struct packed {
		logic yaw_nonzero;
		logic last_read;
		logic out_free;
	} htg_status_t;

endpackage

// File: rtl/htg_if.sv
// ----------------------------------------------------------------------------
// htg channel interfaces
// frame input, result output and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface htg_frame_if;
	logic                                valid;
	logic                                ready;
	logic signed [htg_pkg::YAW_W-1:0]    yaw_angle;
	logic        [htg_pkg::NOW_W-1:0]    now_seconds;

	modport source (output valid, yaw_angle, now_seconds, input ready);
	modport sink   (input valid, yaw_angle, now_seconds, output ready);
endinterface

interface htg_result_if;
	logic                          valid;
	logic                          ready;
	logic                          alert;
	logic [htg_pkg::TURN_W-1:0]    turns_seen;
	logic                          locked;

	modport source (output valid, alert, turns_seen, locked, input ready);
	modport sink   (input valid, alert, turns_seen, locked, output ready);
endinterface

interface htg_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [htg_pkg::CFG_IDX_W-1:0]     index;
	logic [htg_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/htg_ctrl.sv
// ----------------------------------------------------------------------------
// htg_ctrl: sequencing state machine
// steps one frame through load, history update, window read, decision, output
// ----------------------------------------------------------------------------
module htg_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  htg_pkg::htg_status_t status,
	output logic                 in_ready,
	output htg_pkg::htg_cmd_t    cmd
);

	htg_pkg::htg_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= htg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			htg_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = htg_pkg::ST_PREP;
				end
			end
			htg_pkg::ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = status.yaw_nonzero ? htg_pkg::ST_SUM : htg_pkg::ST_SETTLE;
			end
			htg_pkg::ST_SUM: begin
				cmd.issue = 1'b1;
				if (status.last_read) begin
					state_d = htg_pkg::ST_DRAIN;
				end
			end
			htg_pkg::ST_DRAIN: begin
				state_d = htg_pkg::ST_DECIDE;
			end
			htg_pkg::ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = htg_pkg::ST_SETTLE;
			end
			htg_pkg::ST_SETTLE: begin
				cmd.settle = 1'b1;
				state_d    = htg_pkg::ST_EMIT;
			end
			htg_pkg::ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = htg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = htg_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/htg_datapath.sv
// ----------------------------------------------------------------------------
// htg_datapath: registers, history memory, window sums and gesture state
// sums are rebuilt each sample by one memory read a cycle
// ----------------------------------------------------------------------------
module htg_datapath #(
	parameter int unsigned MAX_WINDOW = htg_pkg::MAX_WINDOW_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  htg_pkg::htg_cmd_t                   cmd,
	output htg_pkg::htg_status_t                status,
	// frame payload
	input  logic signed [htg_pkg::YAW_W-1:0]    yaw_angle,
	input  logic        [htg_pkg::NOW_W-1:0]    now_seconds,
	// register writes
	input  logic                                cfg_we,
	input  logic        [htg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [htg_pkg::CFG_DATA_W-1:0] cfg_data,
	// result
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic                                alert,
	output logic        [htg_pkg::TURN_W-1:0]   turns_seen,
	output logic                                locked
);

	localparam int unsigned AW    = $clog2(MAX_WINDOW);
	localparam int unsigned CW    = $clog2(MAX_WINDOW + 1);
	localparam int unsigned SUM_W = htg_pkg::YAW_W + 1 + AW;
	localparam int unsigned TW    = SUM_W + 1;
	localparam int unsigned PW    = htg_pkg::ANGLE_W + 1 + CW;

	// configuration
	logic [htg_pkg::WIN_W-1:0]     short_window_q, long_window_q;
	logic [htg_pkg::ANGLE_W-1:0]   trigger_q, release_q;
	logic [htg_pkg::TIMEOUT_W-1:0] timeout_q;
	logic [htg_pkg::HOLD_W-1:0]    hold_frames_q;
	logic [htg_pkg::TURN_W-1:0]    turns_needed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_window_q <= htg_pkg::SHORT_WINDOW_RST;
			long_window_q  <= htg_pkg::LONG_WINDOW_RST;
			trigger_q      <= htg_pkg::TRIGGER_RST;
			release_q      <= htg_pkg::RELEASE_RST;
			timeout_q      <= htg_pkg::TIMEOUT_RST;
			hold_frames_q  <= htg_pkg::HOLD_RST;
			turns_needed_q <= htg_pkg::TURNS_RST;
		end else if (cfg_we) begin
			unique case (htg_pkg::htg_reg_t'(cfg_index))
				htg_pkg::REG_SHORT_WINDOW:    short_window_q <= cfg_data[htg_pkg::WIN_W-1:0];
				htg_pkg::REG_LONG_WINDOW:     long_window_q  <= cfg_data[htg_pkg::WIN_W-1:0];
				htg_pkg::REG_TRIGGER_ANGLE:   trigger_q      <= cfg_data[htg_pkg::ANGLE_W-1:0];
				htg_pkg::REG_RELEASE_ANGLE:   release_q      <= cfg_data[htg_pkg::ANGLE_W-1:0];
				htg_pkg::REG_TIMEOUT_SECONDS: timeout_q      <= cfg_data;
				htg_pkg::REG_HOLD_FRAMES:     hold_frames_q  <= cfg_data[htg_pkg::HOLD_W-1:0];
				htg_pkg::REG_TURNS_NEEDED:    turns_needed_q <= cfg_data[htg_pkg::TURN_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped window lengths
	logic [CW-1:0] n1, n2, nmax;

	always_comb begin
		if (short_window_q == '0) begin
			n1 = CW'(1);
		end else if (32'(short_window_q) > MAX_WINDOW) begin
			n1 = CW'(MAX_WINDOW);
		end else begin
			n1 = CW'(short_window_q);
		end
		if (long_window_q == '0) begin
			n2 = CW'(1);
		end else if (32'(long_window_q) > MAX_WINDOW) begin
			n2 = CW'(MAX_WINDOW);
		end else begin
			n2 = CW'(long_window_q);
		end
		nmax = (n1 > n2) ? n1 : n2;
	end

	// frame capture
	logic [htg_pkg::YAW_W-1:0] yaw_q;
	logic [htg_pkg::NOW_W-1:0] now_q;
	logic                      expired_q;
	logic [htg_pkg::NOW_W-1:0] elapsed;
	logic [htg_pkg::NOW_W-1:0] period_start_q;

	assign elapsed = now_seconds - period_start_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			yaw_q     <= yaw_angle;
			now_q     <= now_seconds;
			expired_q <= elapsed > {{(htg_pkg::NOW_W-htg_pkg::TIMEOUT_W){1'b0}}, timeout_q};
		end
	end

	assign status.yaw_nonzero = (yaw_q != '0);

	// history ring
	logic [htg_pkg::YAW_W-1:0] hist_mem [MAX_WINDOW];
	logic [AW-1:0]             head_q, rd_ptr_q;
	logic [CW-1:0]             seen_q, seen_next, k_q;
	logic [htg_pkg::YAW_W-1:0] rd_data_s1;
	logic [CW-1:0]             idx_s1;
	logic                      vld_s1;
	logic                      hist_we;

	assign hist_we   = cmd.prep && status.yaw_nonzero;
	assign seen_next = (seen_q < CW'(MAX_WINDOW)) ? seen_q + CW'(1) : seen_q;

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[head_q] <= yaw_q;
		end
		if (cmd.issue) begin
			rd_data_s1 <= hist_mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			seen_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (hist_we) begin
				head_q <= (head_q == AW'(MAX_WINDOW - 1)) ? '0 : head_q + AW'(1);
				seen_q <= seen_next;
			end
			vld_s1 <= cmd.issue;
		end
	end

	// read sweep, newest sample first
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			rd_ptr_q <= head_q;
			k_q      <= '0;
		end else if (cmd.issue) begin
			rd_ptr_q <= (rd_ptr_q == '0) ? AW'(MAX_WINDOW - 1) : rd_ptr_q - AW'(1);
			k_q      <= k_q + CW'(1);
		end
		if (cmd.issue) begin
			idx_s1 <= k_q;
		end
	end

	assign status.last_read = (k_q == nmax - CW'(1));

	// window sums and thresholds
	logic [SUM_W-1:0] short_sum_q, long_sum_q, rd_ext;
	logic             full1_q, full2_q;
	logic [TW-1:0]    thr1_q, thr2_q;
	logic [PW-1:0]    thr1_full, thr2_full;

	assign rd_ext    = {{(SUM_W-htg_pkg::YAW_W){rd_data_s1[htg_pkg::YAW_W-1]}}, rd_data_s1};
	assign thr1_full = PW'({1'b0, trigger_q} + 9'd1) * PW'(n1);
	assign thr2_full = PW'({1'b0, release_q}) * PW'(n2);

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			short_sum_q <= '0;
			long_sum_q  <= '0;
			full1_q     <= seen_next >= n1;
			full2_q     <= seen_next >= n2;
			thr1_q      <= TW'(thr1_full);
			thr2_q      <= TW'(thr2_full);
		end else if (vld_s1) begin
			if (idx_s1 < n1) begin
				short_sum_q <= short_sum_q + rd_ext;
			end
			if (idx_s1 < n2) begin
				long_sum_q <= long_sum_q + rd_ext;
			end
		end
	end

	// |trunc(s/n)| > a  <=>  |s| >= (a+1)*n ;  |trunc(s/n)| < a  <=>  |s| < a*n
	logic [SUM_W-1:0] eff1, eff2;
	logic [TW-1:0]    ext1, ext2, abs1, abs2;
	logic             trig, rel;

	assign eff1 = full1_q ? short_sum_q : '0;
	assign eff2 = full2_q ? long_sum_q : '0;
	assign ext1 = {eff1[SUM_W-1], eff1};
	assign ext2 = {eff2[SUM_W-1], eff2};
	assign abs1 = eff1[SUM_W-1] ? (~ext1 + TW'(1)) : ext1;
	assign abs2 = eff2[SUM_W-1] ? (~ext2 + TW'(1)) : ext2;
	assign trig = abs1 >= thr1_q;
	assign rel  = abs2 < thr2_q;

	// gesture state
	logic [htg_pkg::TURN_W-1:0] turn_q;
	logic                       lock_q, alert_q;
	logic [htg_pkg::HOLD_W-1:0] hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_q         <= '0;
			lock_q         <= 1'b0;
			alert_q        <= 1'b0;
			period_start_q <= '0;
			hold_q         <= '0;
		end else begin
			if (cmd.prep && expired_q) begin
				turn_q <= '0;
				lock_q <= 1'b0;
			end
			if (cmd.decide) begin
				if (trig) begin
					if (!lock_q) begin
						if (turn_q == '0) begin
							period_start_q <= now_q;
						end
						turn_q <= turn_q + htg_pkg::TURN_W'(1);
						lock_q <= 1'b1;
					end
				end else if (rel) begin
					lock_q <= 1'b0;
				end
			end
			if (cmd.settle) begin
				priority if (turn_q == turns_needed_q) begin
					hold_q  <= hold_frames_q;
					alert_q <= 1'b1;
					turn_q  <= '0;
				end else if (hold_q != '0) begin
					hold_q <= hold_q - htg_pkg::HOLD_W'(1);
				end else begin
					alert_q <= 1'b0;
				end
			end
		end
	end

	// output register
	logic out_valid_q;

	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			alert      <= alert_q;
			turns_seen <= turn_q;
			locked     <= lock_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/head_turn_gesture_detector.sv
// ----------------------------------------------------------------------------
// head_turn_gesture_detector: counts head turns from a yaw stream
// sliding-window means with hysteresis, turn timeout and held alert flag
// ----------------------------------------------------------------------------
// sequence: an accepted frame with nonzero yaw steps through the prep, sum, drain,
//   decide, settle and emit states; a no-face frame goes from prep to settle
// throughput: one frame at a time, the next taken only after emit, which waits
//   for a free output; the history read sums one sample per cycle
// reset: arst_n clears registers to their defaults and the history, turn and hold
//   counters; the history memory is not cleared and unwritten entries never reach a mean
// ----------------------------------------------------------------------------
module head_turn_gesture_detector #(
	parameter int unsigned MAX_WINDOW = htg_pkg::MAX_WINDOW_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	htg_frame_if.sink      frames,
	htg_result_if.source   results,
	htg_cfg_if.sink        cfg
);

	htg_pkg::htg_cmd_t    cmd;
	htg_pkg::htg_status_t status;
	logic                 in_ready;

	// sequencer: walks each item through the datapath
	htg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (frames.valid),
		.status   (status),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	// register writes are always taken and act at once, so they belong between frames
	assign cfg.ready    = 1'b1;
	assign frames.ready = in_ready;

	// history ring, window sums, hysteresis and alert state, result register
	htg_datapath #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.yaw_angle   (frames.yaw_angle),
		.now_seconds (frames.now_seconds),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.out_ready   (results.ready),
		.out_valid   (results.valid),
		.alert       (results.alert),
		.turns_seen  (results.turns_seen),
		.locked      (results.locked)
	);

	// one item in flight: no second accept right after one
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(frames.valid && frames.ready) |=> !frames.ready)
		else $error("frame accepted while another item is in flight");

	// a result handed over shows up on the output
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> results.valid)
		else $error("result emitted but output not valid");

	// the sequencer drives at most one command at a time
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command active");

	// results are only emitted into a free output slot
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!results.valid || results.ready))
		else $error("result emitted over a pending one");

endmodule

// File: verif/tb_head_turn_gesture_detector.sv
// ----------------------------------------------------------------------------
// tb_head_turn_gesture_detector: self-checking bench of the head-turn detector
// frames go in through a valid/ready channel and each result is compared
// field by field with a cycle-free model of windows, hysteresis and timeout;
// a directed table is followed by phases of random turn/rest/noise sequences
// ----------------------------------------------------------------------------
module tb_head_turn_gesture_detector;

	localparam int MAXW         = htg_pkg::MAX_WINDOW_DEF;
	// longest frame: both windows at their widest plus the fixed overhead
	localparam int SETTLE_CYC   = htg_pkg::MAX_WINDOW_DEF + 6;
	localparam int PHASES       = 8;
	localparam int PHASE_FRAMES = 66;
	// index past the end of the register map, written to see it ignored
	localparam logic [htg_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

	typedef struct packed {
		logic                       alert;
		logic [htg_pkg::TURN_W-1:0] turns;
		logic                       locked;
	} gesture_t;

	typedef enum logic {ROW_FRAME, ROW_REG} row_kind_t;

	// one row of the directed table: a frame, or a register write
	typedef struct packed {
		row_kind_t                     kind;
		logic [htg_pkg::CFG_IDX_W-1:0] idx;
		logic [15:0]                   val;
		logic [htg_pkg::NOW_W-1:0]     now;
		logic                          typed;
		gesture_t                      res;
	} plan_row_t;

	localparam gesture_t  QUIET = '0;
	localparam int        PLAN_LEN = 33;
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		// first frames after reset: nothing can be flagged yet
		'{ROW_FRAME, '0, 16'd0, 32'd0, 1'b1, QUIET},
		'{ROW_FRAME, '0, 16'd180, 32'd1, 1'b1, QUIET},
		'{ROW_FRAME, '0, -16'sd180, 32'd2, 1'b1, QUIET},
		'{ROW_FRAME, '0, 16'd180, 32'd3, 1'b0, QUIET},
		// short window fills on the row after next and the mean trips the trigger
		'{ROW_FRAME, '0, 16'd180, 32'd4, 1'b0, QUIET},
		// yaw codes beyond +-180 taken as raw two's complement
		'{ROW_FRAME, '0, 16'd255, 32'd5, 1'b0, QUIET},
		'{ROW_FRAME, '0, -16'sd256, 32'd6, 1'b0, QUIET},
		'{ROW_FRAME, '0, -16'sd1, 32'd7, 1'b0, QUIET},
		// no-face frame while locked, then a wrapping time jump
		'{ROW_FRAME, '0, 16'd0, 32'd8, 1'b0, QUIET},
		'{ROW_FRAME, '0, 16'd0, 32'hFFFF_FFFF, 1'b0, QUIET},
		// zero and oversized windows, alert on zero count, all-ones data
		'{ROW_REG, htg_pkg::REG_SHORT_WINDOW, 16'd0, 32'd0, 1'b0, QUIET},
		'{ROW_REG, htg_pkg::REG_LONG_WINDOW, 16'd127, 32'd0, 1'b0, QUIET},
		'{ROW_REG, htg_pkg::REG_TURNS_NEEDED, 16'd0, 32'd0, 1'b0, QUIET},
		'{ROW_REG, htg_pkg::REG_HOLD_FRAMES, 16'd255, 32'd0, 1'b0, QUIET},
		'{ROW_REG, htg_pkg::REG_TRIGGER_ANGLE, 16'd0, 32'd0, 1'b0, QUIET},
		'{ROW_REG, htg_pkg::REG_RELEASE_ANGLE, 16'd180, 32'd0, 1'b0, QUIET},
		'{ROW_REG, htg_pkg::REG_TIMEOUT_SECONDS, 16'hFFFF, 32'd0, 1'b0, QUIET},
		'{ROW_REG, REG_UNMAPPED, 16'hFFFF, 32'd0, 1'b0, QUIET},
		'{ROW_FRAME, '0, 16'd1, 32'd100, 1'b0, QUIET},
		'{ROW_FRAME, '0, -16'sd1, 32'd101, 1'b0, QUIET},
		'{ROW_FRAME, '0, 16'd0, 32'd102, 1'b0, QUIET},
		'{ROW_FRAME, '0, 16'd90, 32'd103, 1'b0, QUIET},
		// opposite extremes of every register
		'{ROW_REG, htg_pkg::REG_SHORT_WINDOW, 16'd64, 32'd0, 1'b0, QUIET},
		'{ROW_REG, htg_pkg::REG_LONG_WINDOW, 16'd1, 32'd0, 1'b0, QUIET},
		'{ROW_REG, htg_pkg::REG_TRIGGER_ANGLE, 16'd180, 32'd0, 1'b0, QUIET},
		'{ROW_REG, htg_pkg::REG_RELEASE_ANGLE, 16'd0, 32'd0, 1'b0, QUIET},
		'{ROW_REG, htg_pkg::REG_TIMEOUT_SECONDS, 16'd1, 32'd0, 1'b0, QUIET},
		'{ROW_REG, htg_pkg::REG_HOLD_FRAMES, 16'd0, 32'd0, 1'b0, QUIET},
		'{ROW_REG, htg_pkg::REG_TURNS_NEEDED, 16'd15, 32'd0, 1'b0, QUIET},
		'{ROW_FRAME, '0, -16'sd180, 32'd200, 1'b0, QUIET},
		'{ROW_FRAME, '0, 16'd180, 32'd201, 1'b0, QUIET},
		'{ROW_FRAME, '0, 16'd0, 32'd205, 1'b0, QUIET},
		'{ROW_FRAME, '0, 16'd5, 32'd206, 1'b0, QUIET}
	};

	logic clk;
	logic arst_n;

	htg_frame_if  frame_ch ();
	htg_result_if result_ch ();
	htg_cfg_if    cfg_ch ();

	head_turn_gesture_detector i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.frames  (frame_ch),
		.results (result_ch),
		.cfg     (cfg_ch)
	);

	// register copies, as the block should hold them
	logic [htg_pkg::WIN_W-1:0]     win_short  = htg_pkg::SHORT_WINDOW_RST;
	logic [htg_pkg::WIN_W-1:0]     win_long   = htg_pkg::LONG_WINDOW_RST;
	logic [htg_pkg::ANGLE_W-1:0]   trig_angle = htg_pkg::TRIGGER_RST;
	logic [htg_pkg::ANGLE_W-1:0]   rel_angle  = htg_pkg::RELEASE_RST;
	logic [htg_pkg::TIMEOUT_W-1:0] timeout_s  = htg_pkg::TIMEOUT_RST;
	logic [htg_pkg::HOLD_W-1:0]    hold_len   = htg_pkg::HOLD_RST;
	logic [htg_pkg::TURN_W-1:0]    turns_need = htg_pkg::TURNS_RST;

	// detector state
	logic signed [htg_pkg::YAW_W-1:0] yaw_hist [MAXW];
	int                               seen_cnt     = 0;
	int                               head_ptr     = 0;
	logic                             lock_flag    = 1'b0;
	logic [htg_pkg::TURN_W-1:0]       turn_cnt     = '0;
	logic [htg_pkg::NOW_W-1:0]        period_start = '0;
	logic [htg_pkg::HOLD_W-1:0]       hold_cnt     = '0;
	logic                             alert_flag   = 1'b0;

	gesture_t pending_gestures [$];

	int  err_cnt     = 0;
	int  frame_cnt   = 0;
	int  checked_cnt = 0;
	int  alert_cnt   = 0;
	int  locked_cnt  = 0;
	int  setting_cnt = 0;
	bit  idle_on     = 1'b1;
	int  stall_left  = 0;
	logic [htg_pkg::NOW_W-1:0] now_s = 32'hFFFF_FFC0;

	// ------------------------------------------------------------------
	// clock, reset and limit
	// ------------------------------------------------------------------
	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("timeout with %0d results outstanding", pending_gestures.size());
		$display("TB_ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// model of the detector
	// ------------------------------------------------------------------

	// window of 0 acts as 1, anything past the history depth as the full depth
	function automatic int clamp_window(logic [htg_pkg::WIN_W-1:0] w);
		if (w == 0)
			return 1;
		if (int'(w) > MAXW)
			return MAXW;
		return int'(w);
	endfunction

	// sum of the newest n samples, walking back from the write pointer
	function automatic int recent_sum(int n);
		int s;
		s = 0;
		for (int i = 0; i < n; i++)
			s += int'(yaw_hist[(head_ptr + 2 * MAXW - 1 - i) % MAXW]);
		return s;
	endfunction

	function automatic gesture_t predict_frame(logic signed [htg_pkg::YAW_W-1:0] yaw,
		logic [htg_pkg::NOW_W-1:0] now);
		int n_short;
		int n_long;
		int mean_short;
		int mean_long;
		int trig;
		int rel;
		logic [htg_pkg::NOW_W-1:0] elapsed;
		gesture_t res;
		// timeout runs on every frame, on the wrapping difference
		elapsed = now - period_start;
		if (elapsed > 32'(timeout_s)) begin
			turn_cnt  = '0;
			lock_flag = 1'b0;
		end
		if (yaw != 0) begin
			n_short = clamp_window(win_short);
			n_long  = clamp_window(win_long);
			yaw_hist[head_ptr] = yaw;
			head_ptr = (head_ptr + 1) % MAXW;
			if (seen_cnt < MAXW)
				seen_cnt++;
			// means stay zero until their window has filled; division truncates
			mean_short = (seen_cnt >= n_short) ? recent_sum(n_short) / n_short : 0;
			mean_long  = (seen_cnt >= n_long) ? recent_sum(n_long) / n_long : 0;
			trig = int'(trig_angle);
			rel  = int'(rel_angle);
			if (mean_short < -trig || mean_short > trig) begin
				if (!lock_flag) begin
					if (turn_cnt == 0)
						period_start = now;
					turn_cnt  = turn_cnt + 1'b1;
					lock_flag = 1'b1;
				end
			end else if (mean_long > -rel && mean_long < rel) begin
				lock_flag = 1'b0;
			end
		end
		if (turn_cnt == turns_need) begin
			hold_cnt   = hold_len;
			alert_flag = 1'b1;
			turn_cnt   = '0;
		end else if (hold_cnt > 0) begin
			hold_cnt--;
		end else begin
			alert_flag = 1'b0;
		end
		res.alert  = alert_flag;
		res.turns  = turn_cnt;
		res.locked = lock_flag;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------

	// offer one frame; valid stays high into the next frame unless a gap is drawn
	task automatic send_frame(logic signed [htg_pkg::YAW_W-1:0] yaw,
		logic [htg_pkg::NOW_W-1:0] now, bit typed, gesture_t typed_res);
		gesture_t res;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			frame_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		frame_ch.valid       <= 1'b1;
		frame_ch.yaw_angle   <= yaw;
		frame_ch.now_seconds <= now;
		@(posedge clk);
		while (!frame_ch.ready)
			@(posedge clk);
		res = predict_frame(yaw, now);
		// typed rows override the model's expectation, so the result is held to the hand value
		pending_gestures = {pending_gestures, (typed ? typed_res : res)};
		frame_cnt++;
	endtask

	// stop sending and let every outstanding result come back
	task automatic drain_results();
		frame_ch.valid <= 1'b0;
		while (pending_gestures.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// caller lowers cfg valid after the last write of a group
	task automatic write_reg(logic [htg_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			htg_pkg::REG_SHORT_WINDOW:    win_short  = val[htg_pkg::WIN_W-1:0];
			htg_pkg::REG_LONG_WINDOW:     win_long   = val[htg_pkg::WIN_W-1:0];
			htg_pkg::REG_TRIGGER_ANGLE:   trig_angle = val[htg_pkg::ANGLE_W-1:0];
			htg_pkg::REG_RELEASE_ANGLE:   rel_angle  = val[htg_pkg::ANGLE_W-1:0];
			htg_pkg::REG_TIMEOUT_SECONDS: timeout_s  = val[htg_pkg::TIMEOUT_W-1:0];
			htg_pkg::REG_HOLD_FRAMES:     hold_len   = val[htg_pkg::HOLD_W-1:0];
			htg_pkg::REG_TURNS_NEEDED:    turns_need = val[htg_pkg::TURN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic flag_mismatch(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		err_cnt++;
	endtask

	// ------------------------------------------------------------------
	// result side: random stall bursts, none in the quiet tail
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (stall_left > 0) begin
			result_ch.ready <= 1'b0;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			result_ch.ready <= 1'b0;
			stall_left = $urandom_range(1, 12) - 1;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	// every accepted result is held against the oldest expectation
	always @(posedge clk) begin
		gesture_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_gestures.size() == 0) begin
				flag_mismatch("result with nothing outstanding");
			end else begin
				want = pending_gestures[0];
				pending_gestures.delete(0);
				checked_cnt++;
				if (result_ch.alert !== want.alert)
					flag_mismatch($sformatf("result %0d alert %b, want %b",
						checked_cnt, result_ch.alert, want.alert));
				if (result_ch.turns_seen !== want.turns)
					flag_mismatch($sformatf("result %0d turns_seen %0d, want %0d",
						checked_cnt, result_ch.turns_seen, want.turns));
				if (result_ch.locked !== want.locked)
					flag_mismatch($sformatf("result %0d locked %b, want %b",
						checked_cnt, result_ch.locked, want.locked));
				if (want.alert)
					alert_cnt++;
				if (want.locked)
					locked_cnt++;
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin
		logic [15:0]                      setting [7];
		logic signed [htg_pkg::YAW_W-1:0] yaw;
		int                               kind;
		int                               seg_len;
		int                               sent;
		int                               mag_lo;
		bit                               neg;

		// every input known from time zero
		arst_n               = 1'b0;
		frame_ch.valid       = 1'b0;
		frame_ch.yaw_angle   = '0;
		frame_ch.now_seconds = '0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.index         = '0;
		cfg_ch.data          = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; register rows come in groups, each after a drain
		for (int r = 0; r < PLAN_LEN; r++) begin
			if (PLAN[r].kind == ROW_REG) begin
				if (r == 0 || PLAN[r-1].kind != ROW_REG)
					drain_results();
				write_reg(PLAN[r].idx, PLAN[r].val);
				if (r == PLAN_LEN - 1 || PLAN[r+1].kind != ROW_REG) begin
					cfg_ch.valid <= 1'b0;
					setting_cnt++;
				end
			end else begin
				send_frame(PLAN[r].val[htg_pkg::YAW_W-1:0], PLAN[r].now, PLAN[r].typed,
					PLAN[r].res);
			end
		end

		// random phases, each under its own register setting
		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			case (p)
				0: setting = '{16'd3, 16'd64, 16'd20, 16'd180, 16'hFFFF, 16'd255, 16'd15};
				1: setting = '{16'd1, 16'd1, 16'd0, 16'd0, 16'd1, 16'd0, 16'd1};
				PHASES - 1: setting = '{16'(htg_pkg::SHORT_WINDOW_RST),
					16'(htg_pkg::LONG_WINDOW_RST), 16'(htg_pkg::TRIGGER_RST),
					16'(htg_pkg::RELEASE_RST), 16'(htg_pkg::TIMEOUT_RST),
					16'(htg_pkg::HOLD_RST), 16'(htg_pkg::TURNS_RST)};
				default: setting = '{16'($urandom_range(1, 8)), 16'($urandom_range(1, 16)),
					16'($urandom_range(10, 60)), 16'($urandom_range(5, 40)),
					16'($urandom_range(5, 200)), 16'($urandom_range(0, 30)),
					16'($urandom_range(1, 4))};
			endcase
			for (int i = 0; i < 7; i++)
				write_reg(htg_pkg::CFG_IDX_W'(i), setting[i]);
			cfg_ch.valid <= 1'b0;
			setting_cnt++;
			// last phase runs with no gaps on either side
			idle_on = (p != PHASES - 1);

			sent = 0;
			while (sent < PHASE_FRAMES) begin
				kind    = $urandom_range(0, 9);
				seg_len = $urandom_range(1, 8);
				neg     = $urandom_range(0, 1);
				mag_lo  = (int'(trig_angle) < 180) ? int'(trig_angle) + 1 : 180;
				if (kind == 9) begin
					// jump across the timeout, right at its edge or far beyond
					if ($urandom_range(0, 1))
						now_s = now_s + 32'(timeout_s) + $urandom_range(0, 2);
					else
						now_s = now_s + $urandom;
				end
				repeat (seg_len) begin
					if (kind <= 3)       // head turned well past the trigger
						yaw = htg_pkg::YAW_W'(neg ? -int'($urandom_range(180, mag_lo))
							: int'($urandom_range(180, mag_lo)));
					else if (kind <= 6)  // looking near straight ahead
						yaw = htg_pkg::YAW_W'(int'($urandom_range(0, 20)) - 10);
					else if (kind == 7)  // no face in view
						yaw = '0;
					else                 // any 9-bit code, out-of-range ones too
						yaw = htg_pkg::YAW_W'($urandom);
					now_s = now_s + $urandom_range(0, 2);
					send_frame(yaw, now_s, 1'b0, QUIET);
					sent++;
				end
			end
		end

		frame_ch.valid <= 1'b0;
		while (pending_gestures.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);

		$display("sent %0d frames under %0d register settings, %0d results checked",
			frame_cnt, setting_cnt, checked_cnt);
		$display("results with alert raised: %0d, with lock held: %0d",
			alert_cnt, locked_cnt);
		if (err_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", err_cnt);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
